// ----- rtl/spq_pkg.sv -----
// Package for the stable sorted priority queue.
// Holds the item and entry types, opcodes and size constants; no dependencies.
`default_nettype none

package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int COUNT_W      = 5;
    localparam int VALUE_W      = 32;
    localparam int PRIO_W       = 16;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;

    localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

    typedef struct packed {
        logic [1:0]                opcode;
        logic signed [VALUE_W-1:0] entry_value;
        logic signed [PRIO_W-1:0]  entry_priority;
    } t_cmd;

    typedef struct packed {
        logic signed [VALUE_W-1:0] front_value;
        logic                      was_empty;
        logic                      overflow;
        logic [COUNT_W-1:0]        entry_count;
    } t_res;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
    } t_entry;

    // Broadcast to every cell of the row
    typedef struct packed {
        logic   ins;
        logic   rem;
        t_entry new_entry;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- rtl/spq_if.sv -----
// Valid/ready channel carrying one payload item per handshake.
// Payload type is a parameter; used with types from spq_pkg.
`default_nettype none

interface spq_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/spq_cell.sv -----
// One slot of the sorted row: holds an entry and trades it with its neighbors.
// Depends on spq_pkg for the entry and control types.
`default_nettype none

module spq_cell (
    input  wire logic               i_clk,
    input  wire spq_pkg::t_cell_ctl i_ctl,
    input  wire logic               i_occupied,
    input  wire logic               i_left_goes,
    input  wire spq_pkg::t_entry    i_left,
    input  wire spq_pkg::t_entry    i_right,
    output logic                    o_goes,
    output spq_pkg::t_entry         o_entry
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // New entry lands at or before this slot when this slot is free or lower priority
    assign o_goes  = !i_occupied || (r_entry.prio < i_ctl.new_entry.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins && o_goes) begin
            if (i_left_goes) begin
                n_entry = i_left;
            end else begin
                n_entry = i_ctl.new_entry;
            end
        end else if (i_ctl.rem) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

// ----- rtl/stable_sorted_priority_queue_top.sv -----
// Top level of the stable sorted priority queue: a row of spq_cell slots,
// an occupancy counter and a result register. Depends on spq_pkg, spq_if, spq_cell.
//
//  channel  | dir | payload                                         | handshake
//  i_cmd    | in  | opcode, entry_value, entry_priority             | valid/ready
//  o_res    | out | front_value, was_empty, overflow, entry_count   | valid/ready
//
// One item per cycle while i_cmd.ready is high: every cell compares against
// the incoming priority and shifts in the same cycle, so the row is updated at
// the accepting edge. The result is registered and valid in the next cycle.
// i_cmd.ready drops only while a result waits and o_res.ready is low.
// Synchronous active-low reset empties the queue; slot contents are not cleared.
`default_nettype none

module stable_sorted_priority_queue_top #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    spq_if.sink       i_cmd,
    spq_if.source     o_res
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    t_res          r_res;
    t_res          n_res;

    t_cell_ctl     cell_ctl;
    t_entry        cell_entry [CAPACITY];
    logic          cell_goes  [CAPACITY];

    logic          accept;
    logic          full;
    logic          empty;
    logic [CW+COUNT_W-1:0] count_wide;

    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign full        = (r_count == CW'(CAPACITY));
    assign empty       = (r_count == '0);

    assign cell_ctl.ins       = accept && (i_cmd.payload.opcode == OP_INSERT) && !full;
    assign cell_ctl.rem       = accept && (i_cmd.payload.opcode == OP_REMOVE) && !empty;
    assign cell_ctl.new_entry.value = i_cmd.payload.entry_value;
    assign cell_ctl.new_entry.prio  = i_cmd.payload.entry_priority;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic   left_goes;
        t_entry left_entry;
        t_entry right_entry;

        if (g == 0) begin : g_head
            assign left_goes  = 1'b0;
            assign left_entry = cell_entry[g];
        end else begin : g_mid
            assign left_goes  = cell_goes[g-1];
            assign left_entry = cell_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_entry = cell_entry[g];
        end else begin : g_body
            assign right_entry = cell_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl),
            .i_occupied  (CW'(g) < r_count),
            .i_left_goes (left_goes),
            .i_left      (left_entry),
            .i_right     (right_entry),
            .o_goes      (cell_goes[g]),
            .o_entry     (cell_entry[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (cell_ctl.ins) begin
            n_count = r_count + CW'(1);
        end else if (cell_ctl.rem) begin
            n_count = r_count - CW'(1);
        end
    end

    assign count_wide = {{COUNT_W{1'b0}}, n_count};

    always_comb begin
        n_res.front_value = '0;
        n_res.was_empty   = 1'b0;
        n_res.overflow    = 1'b0;
        n_res.entry_count = count_wide[COUNT_W-1:0];
        case (i_cmd.payload.opcode)
            OP_INSERT: begin
                n_res.overflow = full;
            end
            OP_REMOVE, OP_PEEK: begin
                n_res.was_empty   = empty;
                n_res.front_value = empty ? EMPTY_VALUE : cell_entry[0].value;
            end
            default: begin
                n_res.front_value = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_res;

endmodule

`default_nettype wire

// ----- dv/stable_sorted_priority_queue_top_tb.sv -----
// Self-checking testbench for stable_sorted_priority_queue_top.
// Drives random insert/remove/peek items under random stalls and checks each result
// against a model of the stable sorted queue. Depends on spq_pkg and spq_if.
`default_nettype none

module stable_sorted_priority_queue_top_tb;

    import spq_pkg::*;

    localparam int          QUEUE_DEPTH = CAPACITY_DEF;
    localparam int          ITEM_TARGET = 1250;
    localparam int          HOLD_CYCLES = 80;
    localparam int          HOLD_AFTER  = 300;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;

    logic clk;
    logic rst_n;

    spq_if #(.T(t_cmd)) cmd_ch ();
    spq_if #(.T(t_res)) res_ch ();

    stable_sorted_priority_queue_top #(
        .CAPACITY(QUEUE_DEPTH)
    ) DUT (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_cmd  (cmd_ch),
        .o_res  (res_ch)
    );

    // Model of the queue contents, front entry at index 0
    logic signed [VALUE_W-1:0] model_values [QUEUE_DEPTH];
    logic signed [PRIO_W-1:0]  model_prios  [QUEUE_DEPTH];
    int                        model_held;

    t_cmd pending_cmds[$];
    t_res expected_results[$];

    int fail_count;
    int cycle_count;
    int results_seen;
    int stat_inserts, stat_overflows, stat_removes, stat_peeks, stat_empty_hits;
    int stat_unused, peak_held;

    int  send_gap, send_calm;
    int  recv_gap, recv_calm;
    int  hold_left;
    bit  hold_done;
    bit  send_fire, recv_take;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Apply one operation to the model and return the result it gives
    function automatic t_res apply_queue_op(t_cmd c);
        t_res r;
        int   pos;
        r = '0;
        case (c.opcode)
            OP_INSERT: begin
                stat_inserts++;
                if (model_held >= QUEUE_DEPTH) begin
                    r.overflow = 1'b1;
                    stat_overflows++;
                end else begin
                    // land behind every entry of greater or equal priority
                    pos = 0;
                    while (pos < model_held && model_prios[pos] >= c.entry_priority)
                        pos++;
                    for (int i = model_held; i > pos; i--) begin
                        model_values[i] = model_values[i-1];
                        model_prios[i]  = model_prios[i-1];
                    end
                    model_values[pos] = c.entry_value;
                    model_prios[pos]  = c.entry_priority;
                    model_held++;
                end
            end
            OP_REMOVE, OP_PEEK: begin
                if (c.opcode == OP_REMOVE) stat_removes++;
                else stat_peeks++;
                if (model_held == 0) begin
                    r.front_value = EMPTY_VALUE;
                    r.was_empty   = 1'b1;
                    stat_empty_hits++;
                end else begin
                    r.front_value = model_values[0];
                    if (c.opcode == OP_REMOVE) begin
                        for (int i = 0; i + 1 < model_held; i++) begin
                            model_values[i] = model_values[i+1];
                            model_prios[i]  = model_prios[i+1];
                        end
                        model_held--;
                    end
                end
            end
            default: stat_unused++;
        endcase
        if (model_held > peak_held) peak_held = model_held;
        r.entry_count = model_held[COUNT_W-1:0];
        return r;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a run with none
    function automatic int pick_gap(inout int calm_left);
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic [PRIO_W-1:0] random_priority();
        int r;
        r = $urandom_range(0, 99);
        // narrow band to get plenty of ties
        if (r < 60) return PRIO_W'($urandom_range(0, 6) - 3);
        if (r < 75) begin
            case ($urandom_range(0, 3))
                0: return 16'h7FFF;
                1: return 16'h8000;
                2: return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        return PRIO_W'($urandom);
    endfunction

    function automatic void push_cmd(logic [1:0] op, logic [VALUE_W-1:0] val,
                                     logic [PRIO_W-1:0] pri);
        t_cmd c;
        c.opcode         = op;
        c.entry_value    = val;
        c.entry_priority = pri;
        pending_cmds.push_back(c);
    endfunction

    function automatic void report_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Driver: offer queued items, compute the expected result at acceptance
    always @(posedge clk) begin
        if (!rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else begin
            send_fire = cmd_ch.valid && cmd_ch.ready;
            if (send_fire)
                expected_results.push_back(apply_queue_op(cmd_ch.payload));
            if (send_fire || !cmd_ch.valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                    cmd_ch.valid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    cmd_ch.payload <= pending_cmds.pop_front();
                    cmd_ch.valid   <= 1'b1;
                    send_gap = pick_gap(send_calm);
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check results in order and drive the receiver's ready
    always @(posedge clk) begin
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            recv_take = res_ch.valid && res_ch.ready;
            if (recv_take) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual value %0d count %0d",
                             $time, res_ch.payload.front_value, res_ch.payload.entry_count);
                    fail_count++;
                end else begin
                    t_res want;
                    want = expected_results.pop_front();
                    report_field("front_value", want.front_value, res_ch.payload.front_value);
                    report_field("was_empty", want.was_empty, res_ch.payload.was_empty);
                    report_field("overflow", want.overflow, res_ch.payload.overflow);
                    report_field("entry_count", want.entry_count, res_ch.payload.entry_count);
                end
                recv_gap = pick_gap(recv_calm);
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AFTER) begin
                // long hold-off so the block backs up into its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                res_ch.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding",
                     $time, expected_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int mode, run, pick, ins_lim, rem_lim, peek_lim;
        logic [1:0] op;
        logic [VALUE_W-1:0] val;

        clk            = 1'b0;
        rst_n          = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.payload = '0;
        res_ch.ready   = 1'b0;

        // Directed: empty-queue reads, unused opcode, fill past capacity, drain a bit
        push_cmd(OP_REMOVE, 32'h1234_5678, 16'h7FFF);
        push_cmd(OP_PEEK,   32'hFFFF_FFFF, 16'h8000);
        push_cmd(OP_UNUSED, 32'hDEAD_BEEF, 16'h5A5A);
        push_cmd(OP_INSERT, 32'h8000_0000, 16'h7FFF);
        push_cmd(OP_INSERT, 32'h7FFF_FFFF, 16'h8000);
        push_cmd(OP_INSERT, 32'h0000_0000, 16'h0000);
        push_cmd(OP_INSERT, 32'hFFFF_FFFF, 16'h0000);
        push_cmd(OP_INSERT, 32'h0000_0005, 16'h0000);
        push_cmd(OP_INSERT, 32'h0000_0006, 16'h7FFF);
        push_cmd(OP_INSERT, 32'h0000_0007, 16'h8000);
        for (int i = 0; i < 9; i++)
            push_cmd(OP_INSERT, 32'h100 + i, PRIO_W'(i % 3 - 1));
        push_cmd(OP_INSERT, 32'hAAAA_5555, 16'h7FFF);
        push_cmd(OP_UNUSED, 32'h5555_AAAA, 16'hA5A5);
        push_cmd(OP_PEEK,   32'h0, 16'h0);
        push_cmd(OP_REMOVE, 32'h0, 16'h0);
        push_cmd(OP_REMOVE, 32'h0, 16'h0);

        // Random phases: fill-heavy, drain-heavy and mixed runs
        while (pending_cmds.size() < ITEM_TARGET) begin
            mode = $urandom_range(0, 2);
            run  = $urandom_range(8, 48);
            case (mode)
                0:       begin ins_lim = 80; rem_lim = 90; peek_lim = 97; end
                1:       begin ins_lim = 15; rem_lim = 85; peek_lim = 96; end
                default: begin ins_lim = 45; rem_lim = 80; peek_lim = 96; end
            endcase
            repeat (run) begin
                pick = $urandom_range(0, 99);
                if (pick < ins_lim)       op = OP_INSERT;
                else if (pick < rem_lim)  op = OP_REMOVE;
                else if (pick < peek_lim) op = OP_PEEK;
                else                      op = OP_UNUSED;
                val = $urandom;
                if ($urandom_range(0, 19) == 0)
                    val = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                push_cmd(op, val, random_priority());
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || cmd_ch.valid) @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Ran %0d results: %0d inserts (%0d overflowed), %0d removes, %0d peeks,",
                 results_seen, stat_inserts, stat_overflows, stat_removes, stat_peeks);
        $display("  %0d empty reads, %0d unused opcodes, peak fill %0d of %0d, %0d mismatches",
                 stat_empty_hits, stat_unused, peak_held, QUEUE_DEPTH, fail_count);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
